@@ hw/rtl/qte_pkg.sv @@
// shared types and constants of the quaternion to euler angle converter
`timescale 1ns / 1ps
package qte_pkg;

	localparam int AtanLen = 24;
	localparam int SqrtSteps = 31;
	localparam int CordicW = 37;

	localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;
	localparam logic [61:0] ONE_Q60 = 62'h1000_0000_0000_0000;
	localparam logic [31:0] ACC_PI = 32'h8000_0000;
	localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

	// atan(2^-i), 2^31 is pi
	localparam logic [31:0] ATAN_TAB [AtanLen] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// operand pairs of the three atan2 evaluations, q.30
	typedef struct packed {
		logic signed [33:0] py;
		logic signed [33:0] px;
		logic signed [33:0] yy;
		logic signed [33:0] yx;
		logic signed [33:0] ry;
		logic signed [33:0] rx;
	} qte_item_t;

endpackage

@@ hw/rtl/qte_if.sv @@
// handshake channels for quaternion beats and euler angle beats
`timescale 1ns / 1ps
interface qte_quat_if;
	logic valid;
	logic ready;
	logic signed [15:0] qw;
	logic signed [15:0] qx;
	logic signed [15:0] qy;
	logic signed [15:0] qz;
	modport source (output valid, output qw, output qx, output qy, output qz, input ready);
	modport sink (input valid, input qw, input qx, input qy, input qz, output ready);
endinterface

interface qte_euler_if;
	logic valid;
	logic ready;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic signed [15:0] roll_angle;
	modport source (output valid, output pitch_angle, output yaw_angle, output roll_angle,
		input ready);
	modport sink (input valid, input pitch_angle, input yaw_angle, input roll_angle,
		output ready);
endinterface

@@ hw/rtl/qte_front.sv @@
// front end: products, asin saturation and pipelined square root for the pitch cosine
`timescale 1ns / 1ps
module qte_front (
	input  logic               clk,
	input  logic               arst_n,
	qte_quat_if.sink           quat,
	output logic               out_valid,
	input  logic               out_ready,
	output qte_pkg::qte_item_t out_item
);
	import qte_pkg::*;

	localparam int NumStages = 3 + SqrtSteps;

	logic [NumStages-1:0] vld_q;
	logic en;

	logic signed [31:0] wx_s1, zy_s1, wy_s1, xz_s1, wz_s1, yx_s1, xx_s1, yy_s1, zz_s1;
	qte_item_t item_s2;
	logic signed [33:0] pdiff, pa, pa_sat;

	logic signed [31:0] a32;
	logic signed [63:0] aa;
	logic [61:0] rad_s3;
	qte_item_t item_s3;

	logic [61:0] rad_q [SqrtSteps+1];
	logic [32:0] rem_q [SqrtSteps+1];
	logic [30:0] root_q [SqrtSteps+1];
	qte_item_t item_q [SqrtSteps+1];

	assign en = !vld_q[NumStages-1] || out_ready;
	assign quat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NumStages-2:0], quat.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat.qw * quat.qx;
			zy_s1 <= quat.qz * quat.qy;
			wy_s1 <= quat.qw * quat.qy;
			xz_s1 <= quat.qx * quat.qz;
			wz_s1 <= quat.qw * quat.qz;
			yx_s1 <= quat.qy * quat.qx;
			xx_s1 <= quat.qx * quat.qx;
			yy_s1 <= quat.qy * quat.qy;
			zz_s1 <= quat.qz * quat.qz;
		end
	end

	// asin argument, saturated to [-1, 1]
	assign pdiff = 34'(wx_s1) - 34'(zy_s1);
	assign pa = pdiff <<< 1;
	always_comb begin
		pa_sat = pa;
		if (pa > ONE_Q30) pa_sat = ONE_Q30;
		if (pa < -ONE_Q30) pa_sat = -ONE_Q30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2.py <= pa_sat;
			item_s2.px <= '0;
			item_s2.yy <= (34'(wy_s1) + 34'(xz_s1)) <<< 1;
			item_s2.yx <= ONE_Q30 - ((34'(yy_s1) + 34'(xx_s1)) <<< 1);
			item_s2.ry <= (34'(wz_s1) + 34'(yx_s1)) <<< 1;
			item_s2.rx <= ONE_Q30 - ((34'(xx_s1) + 34'(zz_s1)) <<< 1);
		end
	end

	assign a32 = item_s2.py[31:0];
	assign aa = a32 * a32;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= ONE_Q60 - aa[61:0];
			item_s3 <= item_s2;
		end
	end

	assign rad_q[0] = rad_s3;
	assign rem_q[0] = '0;
	assign root_q[0] = '0;
	assign item_q[0] = item_s3;

	// one root bit per stage
	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		logic [34:0] cur, trial, diff;
		logic ge;
		assign cur = {rem_q[k], rad_q[k][61-2*k -: 2]};
		assign trial = {2'b00, root_q[k], 2'b01};
		assign diff = cur - trial;
		assign ge = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= ge ? diff[32:0] : cur[32:0];
				root_q[k+1] <= {root_q[k][29:0], ge};
				rad_q[k+1] <= rad_q[k];
				item_q[k+1] <= item_q[k];
			end
		end
	end

	assign out_valid = vld_q[NumStages-1];
	always_comb begin
		out_item = item_q[SqrtSteps];
		out_item.px = 34'(root_q[SqrtSteps]);
	end

endmodule

@@ hw/rtl/qte_fifo.sv @@
// short decoupling queue between front end and cordic back end
`timescale 1ns / 1ps
module qte_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qte_pkg::qte_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output qte_pkg::qte_item_t out_item
);
	import qte_pkg::*;

	localparam int Depth = 4;
	localparam int PtrW = $clog2(Depth);

	qte_item_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrW:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != (PtrW+1)'(Depth);
	assign out_valid = cnt_q != '0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

endmodule

@@ hw/rtl/qte_back.sv @@
// back end: three pipelined vectoring cordic lanes and the output register
`timescale 1ns / 1ps
module qte_back #(
	parameter int Steps = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qte_pkg::qte_item_t in_item,
	qte_euler_if.source        euler
);
	import qte_pkg::*;

	localparam int NumStages = Steps + 1;
	localparam int Lanes = 3;

	logic [NumStages-1:0] vld_q;
	logic en;
	logic signed [33:0] ly [Lanes];
	logic signed [33:0] lx [Lanes];
	logic [15:0] angle [Lanes];

	assign en = !euler.valid || euler.ready;
	assign in_ready = en;

	assign ly[0] = in_item.py;
	assign lx[0] = in_item.px;
	assign ly[1] = in_item.yy;
	assign lx[1] = in_item.yx;
	assign ly[2] = in_item.ry;
	assign lx[2] = in_item.rx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			euler.valid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[NumStages-2:0], in_valid};
			euler.valid <= vld_q[NumStages-1];
		end
	end

	for (genvar l = 0; l < Lanes; l++) begin : g_lane
		logic signed [CordicW-1:0] x_q [Steps+1];
		logic signed [CordicW-1:0] y_q [Steps+1];
		logic [31:0] acc_q [Steps+1];
		logic zero_q [Steps+1];
		logic [31:0] acc_rnd;

		// turn left half-plane vectors by pi
		always_ff @(posedge clk) begin
			if (en) begin
				zero_q[0] <= (ly[l] == '0) && (lx[l] == '0);
				if (lx[l] < 0) begin
					x_q[0] <= -CordicW'(lx[l]);
					y_q[0] <= -CordicW'(ly[l]);
					acc_q[0] <= ACC_PI;
				end else begin
					x_q[0] <= CordicW'(lx[l]);
					y_q[0] <= CordicW'(ly[l]);
					acc_q[0] <= '0;
				end
			end
		end

		for (genvar i = 0; i < Steps; i++) begin : g_step
			logic signed [CordicW-1:0] dx, dy;
			assign dx = y_q[i] >>> i;
			assign dy = x_q[i] >>> i;
			always_ff @(posedge clk) begin
				if (en) begin
					zero_q[i+1] <= zero_q[i];
					if (!y_q[i][CordicW-1]) begin
						x_q[i+1] <= x_q[i] + dx;
						y_q[i+1] <= y_q[i] - dy;
						acc_q[i+1] <= acc_q[i] + ATAN_TAB[i];
					end else begin
						x_q[i+1] <= x_q[i] - dx;
						y_q[i+1] <= y_q[i] + dy;
						acc_q[i+1] <= acc_q[i] - ATAN_TAB[i];
					end
				end
			end
		end

		assign acc_rnd = acc_q[Steps] + ROUND_HALF;
		assign angle[l] = zero_q[Steps] ? 16'h0000 : acc_rnd[31:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			euler.pitch_angle <= angle[0];
			euler.yaw_angle <= angle[1];
			euler.roll_angle <= angle[2];
		end
	end

endmodule

@@ hw/rtl/quaternion_to_euler_angles.sv @@
// top level of the quaternion to euler angle converter
// Takes one quaternion beat per clock and gives one beat of pitch, yaw and roll per clock
// while the output is not stalled, fully pipelined with no dependence between beats. The
// front end registers nine 16x16 products, the asin argument, its square, then one
// square-root bit per stage for 31 stages; beats then pass through the 4-entry queue and
// the back end (pre-rotation, one CORDIC iteration per stage, output register). The front
// and back ends stall independently, the queue absorbing the difference.
`timescale 1ns / 1ps
module quaternion_to_euler_angles #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	qte_quat_if.sink    quat,
	qte_euler_if.source euler
);
	import qte_pkg::*;

	logic f_valid, f_ready, b_valid, b_ready;
	qte_item_t f_item, b_item;

	qte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.quat      (quat),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_item  (f_item)
	);

	qte_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_item  (b_item)
	);

	qte_back #(
		.Steps (CORDIC_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (b_valid),
		.in_ready (b_ready),
		.in_item  (b_item),
		.euler    (euler)
	);

endmodule

@@ hw/rtl/qte_checker.sv @@
// port-level checks of the euler angle output channel, bound to the top level
`timescale 1ns / 1ps
module qte_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               valid,
	input logic               ready,
	input logic signed [15:0] pitch_angle,
	input logic signed [15:0] yaw_angle,
	input logic signed [15:0] roll_angle
);

	// no beat comes out of reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !valid)
		else $error("output beat valid right after reset");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("output beat dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(pitch_angle) && $stable(yaw_angle) && $stable(roll_angle))
		else $error("output payload changed while stalled");

	// pitch is an asin, so it stays near [-pi/2, pi/2]
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> pitch_angle <= 16'sd16640 && pitch_angle >= -16'sd16640)
		else $error("pitch outside half circle");

endmodule

bind quaternion_to_euler_angles qte_port_checker u_qte_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (euler.valid),
	.ready       (euler.ready),
	.pitch_angle (euler.pitch_angle),
	.yaw_angle   (euler.yaw_angle),
	.roll_angle  (euler.roll_angle)
);
